### src/msbr_pkg.sv
// ----------------------------------------------------------------------------
// msbr_pkg: shared types and constants of the MSB-first bit reader
// Opcodes, status codes, register indexes and the command and status
// groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package msbr_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int WINDOW_WIDTH        = 16;
   localparam int COUNT_W             = 5;
   localparam int PBL_W               = 4;
   localparam int ERROR_W             = 16;
   localparam int CONSUMED_W          = 32;
   localparam int CSR_ADDR_W          = 3;
   localparam int CSR_DATA_W          = 32;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_GET  = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_DROPPED  = 2'd1;
   localparam logic [1:0] STATUS_UNDERRUN = 2'd2;

   localparam logic REG_LIMIT_ENABLE = 1'b0;
   localparam logic REG_BYTE_LIMIT   = 1'b1;

   typedef struct packed {
      logic                  limit_enable;
      logic [CONSUMED_W-1:0] byte_limit;
   } cfg_type;

   typedef struct packed {
      logic latch_item;
      logic do_push;
      logic start_get;
      logic shift_bit;
      logic zero_fill;
      logic load_byte;
      logic load_result;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_push;
      logic remaining_zero;
      logic pbl_zero;
      logic underrun;
   } dp_status_type;

endpackage

`default_nettype wire

### src/msbr_csr.sv
// ----------------------------------------------------------------------------
// msbr_csr: configuration registers
// APB-style register file holding the byte limit enable and the byte limit.
// ----------------------------------------------------------------------------
`default_nettype none

module msbr_csr
   import msbr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready,
   output      cfg_type               cfg
);

   logic                  limit_enable_ff, limit_enable_in;
   logic [CONSUMED_W-1:0] byte_limit_ff, byte_limit_in;
   logic                  write_en;
   logic                  reg_sel;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      limit_enable_in = limit_enable_ff;
      byte_limit_in   = byte_limit_ff;
      if (write_en) begin
         case (reg_sel)
            REG_LIMIT_ENABLE: limit_enable_in = csr_pwdata[0];
            REG_BYTE_LIMIT:   byte_limit_in   = csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_enable_ff <= 1'b0;
         byte_limit_ff   <= '0;
      end else begin
         limit_enable_ff <= limit_enable_in;
         byte_limit_ff   <= byte_limit_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_LIMIT_ENABLE: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, limit_enable_ff};
         REG_BYTE_LIMIT:   csr_prdata = byte_limit_ff;
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg.limit_enable = limit_enable_ff;
   assign cfg.byte_limit   = byte_limit_ff;

endmodule

`default_nettype wire

### src/msbr_ctrl.sv
// ----------------------------------------------------------------------------
// msbr_ctrl: sequencing controller
// Accepts one transaction at a time, steps the datapath one bit per cycle
// through a get, pausing for refills, and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msbr_ctrl
   import msbr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_ready,
   output      logic          rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type dp_status,
   output      ctrl_cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_STEP   = 3'd2;
   localparam logic [2:0] ST_READ   = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_item = 1'b1;
               state_in       = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (dp_status.is_push) begin
               cmd.do_push = 1'b1;
               state_in    = ST_FINISH;
            end else begin
               cmd.start_get = 1'b1;
               state_in      = ST_STEP;
            end
         end
         ST_STEP: begin
            if (dp_status.remaining_zero) begin
               state_in = ST_FINISH;
            end else if (dp_status.pbl_zero) begin
               // underrun refills in place; a real byte waits for the queue read
               if (dp_status.underrun) begin
                  cmd.zero_fill = 1'b1;
               end else begin
                  state_in = ST_READ;
               end
            end else begin
               cmd.shift_bit = 1'b1;
            end
         end
         ST_READ: begin
            cmd.load_byte = 1'b1;
            state_in      = ST_STEP;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.load_result = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### src/msbr_dp.sv
// ----------------------------------------------------------------------------
// msbr_dp: bit reader datapath
// Byte queue, lookahead window, partial byte, counters and the result
// register, all driven by controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

module msbr_dp
   import msbr_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cfg_type                 cfg,
   input  wire ctrl_cmd_type            cmd,
   output      dp_status_type           dp_status,
   input  wire logic                    req_opcode,
   input  wire logic [7:0]              req_in_byte,
   input  wire logic [COUNT_W-1:0]      req_bit_count,
   output      logic [WINDOW_WIDTH-1:0] rsp_bits_value,
   output      logic [1:0]              rsp_status,
   output      logic [ERROR_W-1:0]      rsp_error_total
);

   localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IDX_W:0]    DEPTH_SUM  = (IDX_W+1)'(QUEUE_DEPTH);
   localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [FILL_W-1:0] FULL_FILL  = FILL_W'(QUEUE_DEPTH);
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(WINDOW_WIDTH);

   logic [7:0] queue_mem [QUEUE_DEPTH];
   logic [7:0] rd_data_ff;

   logic [WINDOW_WIDTH-1:0] window_ff, window_in;
   logic [7:0]              partial_ff, partial_in;
   logic [PBL_W-1:0]        pbl_ff, pbl_in;
   logic [IDX_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]       fill_ff, fill_in;
   logic [CONSUMED_W-1:0]   consumed_ff, consumed_in;
   logic [ERROR_W-1:0]      error_ff, error_in;

   logic                    op_ff;
   logic [7:0]              byte_ff;
   logic [COUNT_W-1:0]      count_ff;
   logic [COUNT_W-1:0]      remaining_ff, remaining_in;
   logic [WINDOW_WIDTH-1:0] value_ff, value_in;
   logic [1:0]              flag_ff, flag_in;

   logic [WINDOW_WIDTH-1:0] out_value_ff;
   logic [1:0]              out_status_ff;
   logic [ERROR_W-1:0]      out_error_ff;

   logic                    queue_full;
   logic                    underrun;
   logic                    push_write;
   logic [IDX_W:0]          wr_sum;
   logic [IDX_W-1:0]        wr_addr;
   logic [COUNT_W-1:0]      count_clamped;

   assign queue_full = (fill_ff == FULL_FILL);
   assign underrun   = (fill_ff == '0) ||
                       (cfg.limit_enable && (consumed_ff >= cfg.byte_limit));
   assign push_write = cmd.do_push && !queue_full;

   // fill stays below the depth on a write, so one subtract wraps the address
   assign wr_sum  = {1'b0, rd_ptr_ff} + (IDX_W+1)'(fill_ff);
   assign wr_addr = (wr_sum >= DEPTH_SUM) ? IDX_W'(wr_sum - DEPTH_SUM) : wr_sum[IDX_W-1:0];

   assign count_clamped = (req_bit_count > MAX_COUNT) ? MAX_COUNT : req_bit_count;

   always_ff @(posedge clock) begin
      if (push_write) begin
         queue_mem[wr_addr] <= byte_ff;
      end
      rd_data_ff <= queue_mem[rd_ptr_ff];
   end

   always_comb begin
      window_in    = window_ff;
      partial_in   = partial_ff;
      pbl_in       = pbl_ff;
      rd_ptr_in    = rd_ptr_ff;
      fill_in      = fill_ff;
      consumed_in  = consumed_ff;
      error_in     = error_ff;
      remaining_in = remaining_ff;
      value_in     = value_ff;
      flag_in      = flag_ff;

      if (cmd.latch_item) begin
         remaining_in = count_clamped;
         value_in     = '0;
         flag_in      = STATUS_OK;
      end

      if (cmd.do_push) begin
         if (queue_full) begin
            flag_in = STATUS_DROPPED;
         end else begin
            fill_in = fill_ff + 1'b1;
         end
      end

      if (cmd.start_get) begin
         // a shift by the full width yields zero for a zero count
         value_in = window_ff >> (MAX_COUNT - count_ff);
      end

      if (cmd.shift_bit) begin
         window_in    = {window_ff[WINDOW_WIDTH-2:0], partial_ff[7]};
         partial_in   = {partial_ff[6:0], 1'b0};
         pbl_in       = pbl_ff - 1'b1;
         remaining_in = remaining_ff - 1'b1;
      end

      if (cmd.zero_fill) begin
         partial_in = '0;
         pbl_in     = PBL_W'(8);
         flag_in    = STATUS_UNDERRUN;
         if (error_ff != '1) begin
            error_in = error_ff + 1'b1;
         end
      end

      if (cmd.load_byte) begin
         partial_in = rd_data_ff;
         pbl_in     = PBL_W'(8);
         fill_in    = fill_ff - 1'b1;
         rd_ptr_in  = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + 1'b1;
         if (consumed_ff != '1) begin
            consumed_in = consumed_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= '0;
         partial_ff   <= '0;
         pbl_ff       <= '0;
         rd_ptr_ff    <= '0;
         fill_ff      <= '0;
         consumed_ff  <= '0;
         error_ff     <= '0;
         remaining_ff <= '0;
      end else begin
         window_ff    <= window_in;
         partial_ff   <= partial_in;
         pbl_ff       <= pbl_in;
         rd_ptr_ff    <= rd_ptr_in;
         fill_ff      <= fill_in;
         consumed_ff  <= consumed_in;
         error_ff     <= error_in;
         remaining_ff <= remaining_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      flag_ff  <= flag_in;
      if (cmd.latch_item) begin
         op_ff    <= req_opcode;
         byte_ff  <= req_in_byte;
         count_ff <= count_clamped;
      end
      if (cmd.load_result) begin
         out_value_ff  <= value_ff;
         out_status_ff <= flag_ff;
         out_error_ff  <= error_ff;
      end
   end

   assign dp_status.is_push        = (op_ff == OP_PUSH);
   assign dp_status.remaining_zero = (remaining_ff == '0);
   assign dp_status.pbl_zero       = (pbl_ff == '0);
   assign dp_status.underrun       = underrun;

   assign rsp_bits_value  = out_value_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_error_total = out_error_ff;

   a_fill_bounded : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_FILL)
      else $error("queue fill above depth");

   a_pbl_bounded : assert property (@(posedge clock) disable iff (reset)
      pbl_ff <= PBL_W'(8))
      else $error("partial bit count above eight");

   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      cmd.load_byte |-> (fill_ff != '0) && !underrun)
      else $error("byte popped from empty or limited queue");

   a_shift_has_bits : assert property (@(posedge clock) disable iff (reset)
      cmd.shift_bit |-> (pbl_ff != '0) && (remaining_ff != '0))
      else $error("bit shifted without partial bits or demand");

endmodule

`default_nettype wire

### src/msb_first_bit_reader_unit.sv
// ----------------------------------------------------------------------------
// msb_first_bit_reader_unit: MSB-first bit reader
// Top level joining the configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
// One transaction is worked at a time. A push passes through decode and finish
// before the next acceptance. A get passes through decode, then the window
// shifts one bit per cycle, pausing to pull each byte from the queue or to
// shift in a zero byte on underrun; each queue pop waits for the registered
// read of the byte queue. A finished result waits in the output register while
// the next transaction is accepted. Counts above sixteen are treated as sixteen.
`default_nettype none

module msb_first_bit_reader_unit
   import msbr_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_ready,
   input  wire logic                    req_opcode,
   input  wire logic [7:0]              req_in_byte,
   input  wire logic [COUNT_W-1:0]      req_bit_count,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   output      logic [WINDOW_WIDTH-1:0] rsp_bits_value,
   output      logic [1:0]              rsp_status,
   output      logic [ERROR_W-1:0]      rsp_error_total,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]   csr_pwdata,
   output      logic [CSR_DATA_W-1:0]   csr_prdata,
   output      logic                    csr_pready
);

   cfg_type       cfg;
   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   msbr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   msbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   msbr_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .dp_status       (dp_status),
      .req_opcode      (req_opcode),
      .req_in_byte     (req_in_byte),
      .req_bit_count   (req_bit_count),
      .rsp_bits_value  (rsp_bits_value),
      .rsp_status      (rsp_status),
      .rsp_error_total (rsp_error_total)
   );

endmodule

`default_nettype wire

### test/msb_first_bit_reader_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// msb_first_bit_reader_unit_tb: self-checking bench for the MSB-first reader
// Pushes bytes and requests bit fields over the request channel, predicts
// each result from a local copy of window, partial byte, byte queue and
// counters, and compares every response field. Runs through several byte
// limit settings, idle and stall mixes, a long output hold, and a stretch
// where a zero limit starves every refill.
// ----------------------------------------------------------------------------
module msb_first_bit_reader_unit_tb
   import msbr_pkg::*;
;

   localparam int FIFO_DEPTH     = QUEUE_DEPTH_DEFAULT;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 30;

   typedef struct packed {
      logic               op;
      logic [7:0]         push_data;
      logic [COUNT_W-1:0] count;
      logic               drain_first;
   } reader_cmd_type;

   typedef struct packed {
      logic [WINDOW_WIDTH-1:0] bits;
      logic [1:0]              status;
      logic [ERROR_W-1:0]      errors;
   } bit_read_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_opcode = OP_PUSH;
   logic [7:0]              req_in_byte = 8'h00;
   logic [COUNT_W-1:0]      req_bit_count = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [WINDOW_WIDTH-1:0] rsp_bits_value;
   logic [1:0]              rsp_status;
   logic [ERROR_W-1:0]      rsp_error_total;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   // predicted reader state and register copies
   logic [WINDOW_WIDTH-1:0] look_win = '0;
   logic [7:0]              part_byte = '0;
   int unsigned             part_left = 0;
   logic [7:0]              queued_bytes[$];
   logic [CONSUMED_W-1:0]   consumed = '0;
   logic [ERROR_W-1:0]      err_cnt = '0;
   logic                    lim_en = 1'b0;
   logic [CONSUMED_W-1:0]   lim = '0;
   logic                    zero_filled;

   reader_cmd_type pending_cmds[$];
   bit_read_type   expected_reads[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;
   int mismatch_count = 0;
   int push_total = 0;
   int get_total = 0;
   int dropped_pushes = 0;
   int underrun_gets = 0;
   int stall_cycles = 0;
   bit next_drain = 1'b0;

   msb_first_bit_reader_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_in_byte    (req_in_byte),
      .req_bit_count  (req_bit_count),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_bits_value (rsp_bits_value),
      .rsp_status     (rsp_status),
      .rsp_error_total(rsp_error_total),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always #6 clock = ~clock;

   // Next refill byte; a zero byte when the queue is empty or the limit is hit.
   function automatic logic [7:0] pull_refill_byte();
      if (queued_bytes.size() == 0 || (lim_en && consumed >= lim)) begin
         if (err_cnt != 16'hFFFF) err_cnt++;
         zero_filled = 1'b1;
         return 8'h00;
      end
      if (consumed != 32'hFFFF_FFFF) consumed++;
      return queued_bytes.pop_front();
   endfunction

   function automatic void shift_in_bits(int unsigned n);
      logic [31:0] w;
      while (n > part_left) begin
         n -= part_left;
         w = (32'(look_win) << part_left) + (32'(part_byte) >> (8 - part_left));
         look_win = w[15:0];
         part_byte = pull_refill_byte();
         part_left = 8;
      end
      part_left -= n;
      w = (32'(look_win) << n) + (32'(part_byte) >> (8 - n));
      look_win = w[15:0];
      w = 32'(part_byte) << n;
      part_byte = w[7:0];
   endfunction

   function automatic bit_read_type predict_bit_read(logic op, logic [7:0] din,
                                                     logic [COUNT_W-1:0] cnt);
      bit_read_type res;
      int unsigned  n;
      logic [31:0]  w;
      res.bits = '0;
      res.status = STATUS_OK;
      if (op == OP_PUSH) begin
         if (queued_bytes.size() >= FIFO_DEPTH) begin
            res.status = STATUS_DROPPED;
            dropped_pushes++;
         end else begin
            queued_bytes.push_back(din);
         end
      end else begin
         n = (cnt > 16) ? 16 : cnt;
         if (n != 0) begin
            zero_filled = 1'b0;
            w = 32'(look_win) >> (16 - n);
            res.bits = w[15:0];
            shift_in_bits(n);
            if (zero_filled) begin
               res.status = STATUS_UNDERRUN;
               underrun_gets++;
            end
         end
      end
      res.errors = err_cnt;
      return res;
   endfunction

   function automatic void add_cmd(logic op, logic [7:0] din, logic [COUNT_W-1:0] cnt);
      reader_cmd_type c;
      c.op = op;
      c.push_data = din;
      c.count = cnt;
      c.drain_first = next_drain;
      next_drain = 1'b0;
      pending_cmds.push_back(c);
   endfunction

   // Bursts of pushes followed by gets that use up about as many bits,
   // with some single random transactions mixed in.
   task automatic queue_random_traffic(int total);
      int made;
      int pushes;
      int bits_left;
      int n;
      int pick;
      logic [7:0] b;
      made = 0;
      while (made < total) begin
         if ($urandom_range(9) == 0) begin
            add_cmd(1'($urandom_range(1)), 8'($urandom), 5'($urandom));
            made++;
         end else begin
            pushes = ($urandom_range(7) == 0) ? int'($urandom_range(14, 20))
                                              : int'($urandom_range(1, 6));
            for (int i = 0; i < pushes; i++) begin
               pick = $urandom_range(7);
               b = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
               add_cmd(OP_PUSH, b, 5'($urandom));
            end
            made += pushes;
            bits_left = pushes * 8 + int'($urandom_range(12)) - 6;
            while (bits_left > 0 && made < total + 20) begin
               pick = $urandom_range(19);
               n = (pick == 0) ? 0 : (pick == 1) ? int'($urandom_range(17, 31))
                                                 : int'($urandom_range(1, 16));
               add_cmd(OP_GET, 8'($urandom), 5'(n));
               bits_left -= (n > 16) ? 16 : n;
               made++;
            end
         end
      end
   endtask

   task automatic write_csr(logic idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == REG_LIMIT_ENABLE) lim_en = value[0];
      else lim = value;
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() != 0 || expected_reads.size() != 0 || req_valid)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin : driver
      reader_cmd_type cmd;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_reads.push_back(predict_bit_read(req_opcode, req_in_byte,
                                                      req_bit_count));
            if (req_opcode == OP_PUSH) push_total++;
            else get_total++;
         end
         if (!req_valid || req_ready) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                !(pending_cmds[0].drain_first && expected_reads.size() != 0)) begin
               cmd = pending_cmds.pop_front();
               req_valid <= 1'b1;
               req_opcode <= cmd.op;
               req_in_byte <= cmd.push_data;
               req_bit_count <= cmd.count;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin : monitor
      bit_read_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_reads.size() == 0) begin
               $display("%0t: unexpected transaction: bits_value %h status %0d error_total %0d",
                        $time, rsp_bits_value, rsp_status, rsp_error_total);
               mismatch_count++;
            end else begin
               want = expected_reads.pop_front();
               if (rsp_bits_value !== want.bits) begin
                  $display("%0t: bits_value expected %h got %h",
                           $time, want.bits, rsp_bits_value);
                  mismatch_count++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d got %0d",
                           $time, want.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_error_total !== want.errors) begin
                  $display("%0t: error_total expected %0d got %0d",
                           $time, want.errors, rsp_error_total);
                  mismatch_count++;
               end
            end
         end
         if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, no transaction in %0d cycles",
                  $time, WATCHDOG_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : sequencer
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      write_csr(REG_LIMIT_ENABLE, 32'd0);
      write_csr(REG_BYTE_LIMIT, 32'd0);

      // zero count, empty-queue underrun, oversize counts, full-queue drop
      add_cmd(OP_GET, 8'h00, 5'd0);
      add_cmd(OP_GET, 8'hFF, 5'd16);
      add_cmd(OP_PUSH, 8'hFF, 5'd31);
      add_cmd(OP_PUSH, 8'h00, 5'd0);
      add_cmd(OP_PUSH, 8'hA5, 5'd0);
      add_cmd(OP_PUSH, 8'h5A, 5'd0);
      add_cmd(OP_GET, 8'h00, 5'd31);
      add_cmd(OP_GET, 8'h00, 5'd1);
      add_cmd(OP_GET, 8'h00, 5'd7);
      for (int i = 0; i < FIFO_DEPTH; i++) add_cmd(OP_PUSH, 8'($urandom), 5'd0);
      add_cmd(OP_PUSH, 8'hFF, 5'd0);
      wait_drained();

      // back to back, then a long output hold while requests keep coming
      queue_random_traffic(400);
      hold_requests++;
      wait_drained();

      write_csr(REG_BYTE_LIMIT, consumed + 32'd100);
      write_csr(REG_LIMIT_ENABLE, 32'd1);
      send_idle_pct = 73;
      queue_random_traffic(400);
      wait_drained();

      write_csr(REG_BYTE_LIMIT, 32'hFFFF_FFFF);
      send_idle_pct = 0;
      recv_stall_pct = 73;
      queue_random_traffic(400);
      wait_drained();

      write_csr(REG_LIMIT_ENABLE, 32'd0);
      write_csr(REG_BYTE_LIMIT, 32'h0000_1000);
      send_idle_pct = 15;
      recv_stall_pct = 15;
      queue_random_traffic(200);
      next_drain = 1'b1;
      queue_random_traffic(200);
      wait_drained();

      // limit of zero starves every refill
      write_csr(REG_LIMIT_ENABLE, 32'd1);
      write_csr(REG_BYTE_LIMIT, 32'd0);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      queue_random_traffic(60);
      wait_drained();

      write_csr(REG_LIMIT_ENABLE, 32'd0);
      recv_stall_pct = 15;
      queue_random_traffic(60);
      wait_drained();

      $display("Covered %0d pushes and %0d gets across limit off, limited, max and zero limits,",
               push_total, get_total);
      $display("with gaps, stalls and a long hold; %0d drops, %0d underrun gets, errors at %0d.",
               dropped_pushes, underrun_gets, err_cnt);
      if (mismatch_count == 0 && expected_reads.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### files.f
src/msbr_pkg.sv
src/msbr_csr.sv
src/msbr_ctrl.sv
src/msbr_dp.sv
src/msb_first_bit_reader_unit.sv
test/msb_first_bit_reader_unit_tb.sv
